FILE: rtl/pctd_pkg.sv
package pctd_pkg;

    localparam int PCTD_TABLE_ENTRIES = 256;
    localparam int PCTD_MAX_CODE_BITS = 32;
    localparam int MAX_RESULTS        = 8;
    localparam int CFG_W              = 9;
    localparam int CODE_W             = 32;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_command;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        t_command            command;
        logic [7:0]          entry_index;
        logic [7:0]          entry_symbol;
        logic [5:0]          entry_length;
        logic [CODE_W-1:0]   entry_code;
        logic [7:0]          data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       status;
    } t_out_item;

    typedef struct packed {
        logic [7:0]        symbol;
        logic [5:0]        length;
        logic [CODE_W-1:0] code;
    } t_entry;

    typedef struct packed {
        logic load;
        logic clear;
        logic append;
        logic overflow;
        logic scan;
        logic take_hit;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic last_slot;
        logic overflow;
    } t_ctrl_sts;

endpackage

FILE: rtl/prefix_code_table_decoder_core.sv
// Prefix code table decoder.
// Input items arrive on i_item and are taken at a clock edge where start is
// high and busy is low. Commands: load a table entry, append a byte to the
// bit buffer, or clear the buffer. The entry count register is written by
// i_cfg_wr_en / i_cfg_wr_data; the user must write it only while the block
// is idle, and the block itself does not enforce this. Results leave on
// o_result, one per cycle where o_strobe is high; there is no back-pressure,
// the receiver must take every item.
// Load, clear: no result. An append that would overflow the buffer gives a
// single overflow item in the cycle after acceptance.
// Append: each decode pass reads the table through one memory port, one slot
// a cycle, over slots 0 to N - 1 with N = min(entries in use, table size),
// and ends at the first match. At most eight symbols per byte; busy stays
// high while the passes run. A symbol leaves on the cycle after the following
// pass finds its own match or none, so the last one can be flagged; the last
// one leaves on the first cycle with busy low again.
// Reset empties the bit buffer, zeroes the entry count and idles the
// controller; table contents are undefined until loaded.
module prefix_code_table_decoder_core import pctd_pkg::*; #(
    parameter int TABLE_ENTRIES = PCTD_TABLE_ENTRIES,
    parameter int MAX_CODE_BITS = PCTD_MAX_CODE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    output logic             o_strobe,
    output t_out_item        o_result
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    pctd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    pctd_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_strobe      (o_strobe),
        .o_result      (o_result)
    );

endmodule

FILE: rtl/pctd_ctrl.sv
module pctd_ctrl import pctd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_command  i_command,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd,
    output logic      o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_command == CMD_APPEND && !i_sts.overflow) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.hit) begin
                    n_state = i_sts.last_slot ? ST_FLUSH : ST_SCAN;
                end else if (i_sts.scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    case (i_command)
                        CMD_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        CMD_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        CMD_APPEND: begin
                            o_cmd.append   = !i_sts.overflow;
                            o_cmd.overflow = i_sts.overflow;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan     = 1'b1;
                o_cmd.take_hit = i_sts.hit;
                o_cmd.finish   = !i_sts.hit && i_sts.scan_end;
            end
            ST_FLUSH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/pctd_datapath.sv
module pctd_datapath import pctd_pkg::*; #(
    parameter int TABLE_ENTRIES = PCTD_TABLE_ENTRIES,
    parameter int MAX_CODE_BITS = PCTD_MAX_CODE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_item,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  t_ctrl_cmd        i_cmd,
    output t_ctrl_sts        o_sts,
    output logic             o_strobe,
    output t_out_item        o_result
);

    localparam int AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IW  = $clog2(TABLE_ENTRIES + 1);
    localparam int BW  = MAX_CODE_BITS + 8;
    localparam int CW  = $clog2(BW + 1);
    localparam int XW  = (BW > CODE_W) ? BW : CODE_W;
    localparam int NRW = $clog2(MAX_RESULTS + 1);

    function automatic logic [XW-1:0] low_mask(input logic [7:0] n);
        low_mask = ~({XW{1'b1}} << n);
    endfunction

    t_entry           r_mem [TABLE_ENTRIES];
    t_entry           r_rd;
    logic             r_cmp_valid;
    logic [IW-1:0]    r_idx;
    logic [BW-1:0]    r_buf;
    logic [CW-1:0]    r_count;
    logic [CFG_W-1:0] r_eiu;
    logic             r_pend_valid;
    logic [7:0]       r_pend_sym;
    logic [NRW-1:0]   r_nres;
    logic             r_strobe;
    t_out_item        r_result;

    logic [IW-1:0]    limit;
    logic             issue;
    logic             len_ok;
    logic [XW-1:0]    len_mask;
    logic [XW-1:0]    top;
    logic [XW-1:0]    code_x;
    logic [CW-1:0]    n_count;
    logic [BW-1:0]    n_buf;
    t_entry           wr_entry;

    assign limit = (int'(r_eiu) > TABLE_ENTRIES) ? IW'(TABLE_ENTRIES) : IW'(r_eiu);
    assign issue = i_cmd.scan && (r_idx < limit);

    assign len_mask = low_mask(8'(r_rd.length));
    assign code_x   = XW'(r_rd.code) & len_mask;
    assign top      = (XW'(r_buf) >> (r_count - CW'(r_rd.length))) & len_mask;
    assign len_ok   = (r_rd.length != '0) && (int'(r_rd.length) <= MAX_CODE_BITS)
                      && (int'(r_rd.length) <= int'(r_count));
    assign n_count  = r_count - CW'(r_rd.length);
    assign n_buf    = r_buf & BW'(low_mask(8'(n_count)));

    assign o_sts.hit       = r_cmp_valid && len_ok && (top == code_x);
    assign o_sts.scan_end  = !r_cmp_valid && (r_idx >= limit);
    assign o_sts.last_slot = (r_nres == NRW'(MAX_RESULTS - 1));
    assign o_sts.overflow  = int'(r_count) > MAX_CODE_BITS;

    assign wr_entry.symbol = i_item.entry_symbol;
    assign wr_entry.length = i_item.entry_length;
    assign wr_entry.code   = i_item.entry_code;

    // code table
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && int'(i_item.entry_index) < TABLE_ENTRIES) begin
            r_mem[i_item.entry_index[AW-1:0]] <= wr_entry;
        end
        if (issue) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid  <= 1'b0;
            r_idx        <= '0;
            r_buf        <= '0;
            r_count      <= '0;
            r_eiu        <= '0;
            r_pend_valid <= 1'b0;
            r_nres       <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= i_cmd.overflow || ((i_cmd.take_hit || i_cmd.finish) && r_pend_valid);
            if (i_cfg_wr_en) begin
                r_eiu <= i_cfg_wr_data;
            end
            // a hit changes the buffer, so the scan restarts from slot 0
            if (i_cmd.append || i_cmd.take_hit) begin
                r_idx       <= '0;
                r_cmp_valid <= 1'b0;
            end else begin
                r_cmp_valid <= issue;
                if (issue) begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            if (i_cmd.clear) begin
                r_buf   <= '0;
                r_count <= '0;
            end
            if (i_cmd.append) begin
                r_buf        <= {r_buf[BW-9:0], i_item.data_byte};
                r_count      <= r_count + CW'(8);
                r_nres       <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.take_hit) begin
                r_count      <= n_count;
                r_buf        <= n_buf;
                r_pend_valid <= 1'b1;
                r_nres       <= r_nres + NRW'(1);
            end
            if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // item payload; a decoded symbol is held back until it is known whether it is the last
    always_ff @(posedge i_clk) begin
        if (i_cmd.overflow) begin
            r_result <= '{symbol: 8'd0, last: 1'b1, status: 1'b1};
        end else if (i_cmd.take_hit) begin
            r_result <= '{symbol: r_pend_sym, last: 1'b0, status: 1'b0};
        end else if (i_cmd.finish) begin
            r_result <= '{symbol: r_pend_sym, last: 1'b1, status: 1'b0};
        end
        if (i_cmd.take_hit) begin
            r_pend_sym <= r_rd.symbol;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: rtl/pctd_checker.sv
module pctd_checker import pctd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_item,
    input logic      o_strobe,
    input t_out_item o_result
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("strobe or busy after reset");

    a_overflow_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status) |-> (o_result.last && o_result.symbol == 8'd0))
        else $error("malformed overflow item");

    a_load_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.command == CMD_LOAD || i_item.command == CMD_CLEAR))
        |=> (!o_strobe && !busy))
        else $error("load or clear produced an item");

    a_append_reacts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.command == CMD_APPEND)
        |=> (busy || (o_strobe && o_result.status)))
        else $error("append neither decoded nor flagged overflow");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.status && !o_result.last) |-> busy)
        else $error("non-final item while idle");

endmodule

bind prefix_code_table_decoder_core pctd_checker u_pctd_checker (.*);

FILE: sim/prefix_code_table_decoder_core_tb.sv
`timescale 1ns / 1ps

module prefix_code_table_decoder_core_tb;
    import pctd_pkg::*;

    localparam int BUF_BITS = PCTD_MAX_CODE_BITS + 8;
    localparam t_command CMD_UNUSED = t_command'(2'b11);

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in_item         item = '0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             o_strobe;
    t_out_item        o_result;
    bit               gaps_on = 1'b1;

    class decode_scoreboard;
        t_entry      slots[PCTD_TABLE_ENTRIES];
        logic [63:0] bits;
        int unsigned nbits;
        int unsigned n_entries;
        t_out_item   pending[$];
        int          errors;

        function new();
            foreach (slots[i]) slots[i] = '0;
            bits = '0;
            nbits = 0;
            n_entries = 0;
            errors = 0;
        endfunction

        function int unsigned scan_limit();
            return (n_entries > PCTD_TABLE_ENTRIES) ? PCTD_TABLE_ENTRIES : n_entries;
        endfunction

        function logic [63:0] low_bits(int unsigned n);
            return (64'd1 << n) - 64'd1;
        endfunction

        function void note_item(t_in_item it);
            logic [7:0]  syms[MAX_RESULTS];
            int          count;
            int          hit;
            int unsigned len;
            t_out_item   res;
            case (it.command)
                CMD_LOAD: begin
                    slots[it.entry_index].symbol = it.entry_symbol;
                    slots[it.entry_index].length = it.entry_length;
                    slots[it.entry_index].code   = it.entry_code;
                end
                CMD_CLEAR: begin
                    bits  = '0;
                    nbits = 0;
                end
                CMD_APPEND: begin
                    if (nbits + 8 > BUF_BITS) begin
                        res.symbol = 8'd0;
                        res.last   = 1'b1;
                        res.status = 1'b1;
                        pending.push_back(res);
                    end else begin
                        bits  = ((bits << 8) | 64'(it.data_byte)) & low_bits(nbits + 8);
                        nbits = nbits + 8;
                        count = 0;
                        hit   = 0;
                        while (count < MAX_RESULTS && hit >= 0) begin
                            hit = -1;
                            for (int i = 0; i < int'(scan_limit()) && hit < 0; i++) begin
                                len = slots[i].length;
                                if (len != 0 && len <= PCTD_MAX_CODE_BITS && len <= nbits &&
                                    ((bits >> (nbits - len)) & low_bits(len)) ==
                                    (64'(slots[i].code) & low_bits(len)))
                                    hit = i;
                            end
                            if (hit >= 0) begin
                                nbits = nbits - slots[hit].length;
                                bits  = bits & low_bits(nbits);
                                syms[count] = slots[hit].symbol;
                                count++;
                            end
                        end
                        for (int k = 0; k < count; k++) begin
                            res.symbol = syms[k];
                            res.last   = (k == count - 1);
                            res.status = 1'b0;
                            pending.push_back(res);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual sym=%02h last=%0b status=%0b",
                         $time, got.symbol, got.last, got.status);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                $display({"%0t: mismatch, expected sym=%02h last=%0b status=%0b,",
                          " actual sym=%02h last=%0b status=%0b"},
                         $time, want.symbol, want.last, want.status,
                         got.symbol, got.last, got.status);
            end
        endfunction
    endclass

    decode_scoreboard sb = new();

    prefix_code_table_decoder_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (item),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .o_strobe     (o_strobe),
        .o_result     (o_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    function automatic t_in_item mk(t_command c, logic [7:0] idx, logic [7:0] sym,
                                    logic [5:0] len, logic [31:0] code, logic [7:0] dbyte);
        t_in_item it;
        it.command      = c;
        it.entry_index  = idx;
        it.entry_symbol = sym;
        it.entry_length = len;
        it.entry_code   = code;
        it.data_byte    = dbyte;
        return it;
    endfunction

    // mostly short codes so that decodes are frequent
    function automatic t_entry rand_entry();
        t_entry      e;
        int unsigned pick;
        pick     = $urandom_range(0, 99);
        e.symbol = 8'($urandom);
        e.code   = $urandom;
        if (pick < 5)       e.length = 6'd0;
        else if (pick < 10) e.length = 6'($urandom_range(33, 63));
        else if (pick < 22) e.length = 6'($urandom_range(7, 32));
        else                e.length = 6'($urandom_range(1, 5));
        return e;
    endfunction

    function automatic t_in_item make_load(logic [7:0] idx, t_entry e);
        return mk(CMD_LOAD, idx, e.symbol, e.length, e.code, 8'($urandom));
    endfunction

    task automatic push_item(t_in_item it);
        while (gaps_on && $urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic wait_results();
        while (sb.pending.size() != 0) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic settle();
        wait_results();
        repeat (8 * (sb.scan_limit() + 2) + 4) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        while (busy) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_entries(int unsigned v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(v);
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.n_entries = v;
    endtask

    task automatic random_step();
        t_in_item    it;
        t_entry      e;
        int unsigned pick;
        if ($urandom_range(0, 99) < 3) wait_results();
        it   = t_in_item'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            it.command = CMD_APPEND;
        end else if (pick < 82) begin
            e  = rand_entry();
            it = make_load(8'($urandom), e);
        end else if (pick < 92) begin
            it.command = CMD_CLEAR;
        end else begin
            it.command = CMD_UNUSED;
        end
        push_item(it);
    endtask

    initial begin
        int unsigned phase_entries[6] = '{1, 12, 3, 10, 7, 2};
        int unsigned n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty scan range: nothing decodes, buffer fills and then overflows
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'hFF));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'h00));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'hAA));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'h55));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'h01));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'h80));
        push_item(mk(CMD_UNUSED, 8'hFF, 8'hFF, 6'h3F, 32'hFFFF_FFFF, 8'hFF));
        push_item(mk(CMD_CLEAR, 8'h00, 8'h00, 6'd0, 32'h0, 8'h00));

        // full-width code, unused slot, over-long code, stray high code bits
        push_item(mk(CMD_LOAD, 8'd0, 8'hFF, 6'd32, 32'hA5C3_0F96, 8'h00));
        push_item(mk(CMD_LOAD, 8'd1, 8'h00, 6'd0, 32'h0, 8'h00));
        push_item(mk(CMD_LOAD, 8'd2, 8'h5A, 6'd63, 32'hFFFF_FFFF, 8'h00));
        push_item(mk(CMD_LOAD, 8'd3, 8'h11, 6'd4, 32'hFFFF_FFF5, 8'h00));
        push_item(mk(CMD_LOAD, 8'd4, 8'h22, 6'd1, 32'h0, 8'h00));
        push_item(mk(CMD_LOAD, 8'd255, 8'hEE, 6'd8, 32'h0000_00FF, 8'h00));
        settle();
        write_entries(5);

        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'hA5));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'hC3));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'h0F));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'h96));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'h00));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'h05));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'h7F));
        push_item(mk(CMD_CLEAR, 8'h00, 8'h00, 6'd0, 32'h0, 8'h00));

        // entry count above the table size: one-bit codes in the first two
        // slots decode every bit, so each byte gives eight symbols and no pass
        // runs past them
        push_item(mk(CMD_LOAD, 8'd0, 8'h30, 6'd1, 32'h0, 8'h00));
        push_item(mk(CMD_LOAD, 8'd1, 8'h31, 6'd1, 32'h1, 8'h00));
        settle();
        write_entries(511);
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'h5A));
        push_item(mk(CMD_APPEND, 8'h00, 8'h00, 6'd0, 32'h0, 8'($urandom)));

        foreach (phase_entries[p]) begin
            settle();
            n = phase_entries[p];
            write_entries(n);
            gaps_on = (p != 3);
            for (int j = 0; j < n && j < 12; j++) push_item(make_load(8'(j), rand_entry()));
            repeat (15) random_step();
        end

        settle();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
